// ===== rtl/core/triangle_unit_normal_defines.svh =====
// assertion macros for the triangle unit normal block
// used by the port checker; expects clk and rst in scope
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// property that holds in the same cycle or across cycles
`define TUN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent followed by consequent in the next cycle
`define TUN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tun_pkg.sv =====
// shared types and constants for the triangle unit normal block
// no dependencies
`timescale 1ns / 1ps

package tun_pkg;

  localparam int IDX_BITS   = 12;
  localparam int POS_BITS   = 24;
  localparam int EDGE_LIMIT = 29;
  localparam int EDGE_BITS  = 30;
  localparam int PROD_BITS  = 60;
  localparam int CROSS_BITS = 61;
  localparam int MAG_BITS   = 30;
  localparam int SQ_BITS    = 60;
  localparam int SUM_BITS   = 62;
  localparam int ROOT_BITS  = 31;
  localparam int QUO_BITS   = 15;
  localparam int NORM_BITS  = 16;
  localparam int LEAD_POS   = 29;
  localparam int GROUP_BITS = 8;
  localparam int GROUPS     = 8;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RD_B,
    SEQ_RD_C
  } seq_t;

  typedef struct packed {
    logic                       mode;
    logic [IDX_BITS-1:0]        index_a;
    logic [IDX_BITS-1:0]        index_b;
    logic [IDX_BITS-1:0]        index_c;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic                        degenerate;
  } result_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } flags_t;

  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [SUM_BITS-1:0]      sum;
    flags_t                   flags;
  } norm_t;

endpackage

// ===== rtl/core/tun_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tun_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/tun_fetch.sv =====
// vertex store and read sequencer: writes positions, reads three vertices per query
// depends on tun_pkg and tun_ram
`timescale 1ns / 1ps

module tun_fetch #(
  parameter int VERTEX_COUNT = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  tun_pkg::item_t                    item,
  output logic                              port_free,
  output logic                              vtx_valid,
  output logic [2:0][2:0][COORD_BITS-1:0]   vtx
);

  import tun_pkg::*;

  localparam int ADDR_BITS = $clog2(VERTEX_COUNT);
  localparam int EXT_BITS  = ADDR_BITS > IDX_BITS ? ADDR_BITS : IDX_BITS;
  localparam int WORD_BITS = 3 * COORD_BITS;

  seq_t                      seq, seq_next;
  logic [IDX_BITS-1:0]       idx_b, idx_c, rd_idx;
  logic [EXT_BITS-1:0]       rd_ext;
  logic                      rd_ok, we, issue;
  logic [2:0][COORD_BITS-1:0] wdata, arr_data, va, vb;
  logic [WORD_BITS-1:0]      rdata;
  logic                      arr_valid, arr_ok;
  seq_t                      arr_kind;

  assign port_free = seq == SEQ_IDLE;

  always_comb begin
    case (seq)
      SEQ_IDLE: rd_idx = item.index_a;
      SEQ_RD_B: rd_idx = idx_b;
      default:  rd_idx = idx_c;
    endcase
  end

  assign rd_ext   = EXT_BITS'(rd_idx);
  assign rd_ok    = 32'(rd_idx) < VERTEX_COUNT;
  assign we       = take && item.mode == MODE_WRITE && rd_ok;
  assign issue    = (seq == SEQ_IDLE && take && item.mode == MODE_QUERY) || seq != SEQ_IDLE;
  assign wdata[0] = COORD_BITS'(32'(item.pos_x));
  assign wdata[1] = COORD_BITS'(32'(item.pos_y));
  assign wdata[2] = COORD_BITS'(32'(item.pos_z));

  tun_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (VERTEX_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (rd_ext[ADDR_BITS-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_IDLE: begin
        if (take && item.mode == MODE_QUERY) begin
          seq_next = SEQ_RD_B;
        end
      end
      SEQ_RD_B: seq_next = SEQ_RD_C;
      default:  seq_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      arr_valid <= 1'b0;
      vtx_valid <= 1'b0;
    end else begin
      seq       <= seq_next;
      arr_valid <= issue;
      vtx_valid <= arr_valid && arr_kind == SEQ_RD_C;
    end
  end

  // out-of-range vertices read as the origin
  assign arr_data = arr_ok ? rdata : '0;

  always_ff @(posedge clk) begin
    if (seq == SEQ_IDLE && take) begin
      idx_b <= item.index_b;
      idx_c <= item.index_c;
    end
    arr_kind <= seq;
    arr_ok   <= rd_ok;
    if (arr_valid && arr_kind == SEQ_IDLE) begin
      va <= arr_data;
    end
    if (arr_valid && arr_kind == SEQ_RD_B) begin
      vb <= arr_data;
    end
    vtx[0] <= va;
    vtx[1] <= vb;
    vtx[2] <= arr_data;
  end

endmodule

// ===== rtl/core/tun_cross.sv =====
// edge vectors, cross product, block normalisation and sum of squares
// depends on tun_pkg
`timescale 1ns / 1ps

module tun_cross #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vtx_valid,
  input  logic [2:0][2:0][COORD_BITS-1:0] vtx,
  output logic                            norm_valid,
  output tun_pkg::norm_t                  norm
);

  import tun_pkg::*;

  localparam int PRE_SHIFT = COORD_BITS > EDGE_LIMIT ? COORD_BITS - EDGE_LIMIT : 0;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PAD_BITS  = GROUPS * GROUP_BITS;
  localparam int POS_W     = $clog2(GROUP_BITS);
  localparam int LEAD_W    = $clog2(PAD_BITS);

  function automatic logic signed [EDGE_BITS-1:0] edge_of(input logic [COORD_BITS-1:0] p,
                                                         input logic [COORD_BITS-1:0] q);
    logic signed [DIFF_BITS-1:0] d;
    logic [DIFF_BITS-1:0]        m;
    logic [EDGE_BITS-1:0]        s;
    d = DIFF_BITS'($signed(p)) - DIFF_BITS'($signed(q));
    m = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    s = EDGE_BITS'(m >> PRE_SHIFT);
    return d[DIFF_BITS-1] ? -$signed(s) : $signed(s);
  endfunction

  logic [7:0]                   v;
  logic signed [EDGE_BITS-1:0]  e1 [3];
  logic signed [EDGE_BITS-1:0]  e2 [3];
  logic signed [PROD_BITS-1:0]  prod [6];
  logic signed [CROSS_BITS-1:0] cross_c [3];
  logic [CROSS_BITS-1:0]        cmag [3];
  logic [2:0]                   cneg;
  logic [PAD_BITS-1:0]          lead_or;
  logic [GROUPS-1:0]            grp_any_c, grp_any;
  logic [POS_W-1:0]             grp_pos_c [GROUPS];
  logic [POS_W-1:0]             grp_pos [GROUPS];
  logic [CROSS_BITS-1:0]        mag4 [3];
  logic [2:0]                   neg4;
  logic [LEAD_W-1:0]            lead_c, lead5;
  logic [CROSS_BITS-1:0]        mag5 [3];
  logic [2:0]                   neg5;
  logic                         degen5;
  logic [63:0]                  shifted [3];
  logic [2:0][MAG_BITS-1:0]     mag6, mag7;
  logic [2:0]                   neg6, neg7;
  logic                         degen6, degen7;
  logic [SQ_BITS-1:0]           sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[6:0], vtx_valid};
    end
  end

  assign norm_valid = v[7];

  // cross product components and their magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cross_c[k] = CROSS_BITS'(prod[2*k]) - CROSS_BITS'(prod[2*k+1]);
    end
  end

  // leading one of the largest magnitude, found per byte
  always_comb begin
    lead_or = PAD_BITS'(cmag[0] | cmag[1] | cmag[2]);
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_c[g] = |lead_or[g*GROUP_BITS +: GROUP_BITS];
      grp_pos_c[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        if (lead_or[g*GROUP_BITS + b]) begin
          grp_pos_c[g] = POS_W'(b);
        end
      end
    end
  end

  always_comb begin
    lead_c = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_any[g]) begin
        lead_c = LEAD_W'(g * GROUP_BITS) + LEAD_W'(grp_pos[g]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lead5 >= LEAD_W'(LEAD_POS)) begin
        shifted[k] = 64'(mag5[k]) >> (lead5 - LEAD_W'(LEAD_POS));
      end else begin
        shifted[k] = 64'(mag5[k]) << (LEAD_W'(LEAD_POS) - lead5);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1[k] <= edge_of(vtx[1][k], vtx[0][k]);
      e2[k] <= edge_of(vtx[2][k], vtx[0][k]);
    end
    prod[0] <= e1[1] * e2[2];
    prod[1] <= e1[2] * e2[1];
    prod[2] <= e1[2] * e2[0];
    prod[3] <= e1[0] * e2[2];
    prod[4] <= e1[0] * e2[1];
    prod[5] <= e1[1] * e2[0];
    for (int k = 0; k < 3; k++) begin
      cneg[k] <= cross_c[k][CROSS_BITS-1];
      cmag[k] <= cross_c[k][CROSS_BITS-1] ? CROSS_BITS'(-cross_c[k]) : CROSS_BITS'(cross_c[k]);
    end
    grp_any <= grp_any_c;
    grp_pos <= grp_pos_c;
    mag4    <= cmag;
    neg4    <= cneg;
    lead5   <= lead_c;
    mag5    <= mag4;
    neg5    <= neg4;
    degen5  <= ~|grp_any;
    for (int k = 0; k < 3; k++) begin
      mag6[k] <= MAG_BITS'(shifted[k]);
      sq[k]   <= SQ_BITS'(mag6[k]) * SQ_BITS'(mag6[k]);
    end
    neg6   <= neg5;
    degen6 <= degen5;
    mag7   <= mag6;
    neg7   <= neg6;
    degen7 <= degen6;
    norm.mag         <= mag7;
    norm.sum         <= SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
    norm.flags.neg   <= neg7;
    norm.flags.degen <= degen7;
  end

endmodule

// ===== rtl/core/tun_scale.sv =====
// pipelined square root and three-lane division to a unit normal in q1.14
// depends on tun_pkg
`timescale 1ns / 1ps

module tun_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             norm_valid,
  input  tun_pkg::norm_t   norm,
  output logic             res_valid,
  output tun_pkg::result_t res
);

  import tun_pkg::*;

  localparam int DEN_BITS = ROOT_BITS + 1;
  localparam int NUM_BITS = MAG_BITS + QUO_BITS + 2;
  localparam int DEPTH    = ROOT_BITS + QUO_BITS + 3;

  function automatic logic signed [NORM_BITS-1:0] apply_sign(input logic [QUO_BITS-1:0] q,
                                                            input logic neg);
    logic signed [NORM_BITS-1:0] w;
    w = $signed(NORM_BITS'(q));
    return neg ? -w : w;
  endfunction

  logic [DEPTH-1:0]          vchain;

  logic [SUM_BITS-1:0]       sq_rem   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]      sq_root  [ROOT_BITS+1];
  logic [2:0][MAG_BITS-1:0]  sq_mag   [ROOT_BITS+1];
  flags_t                    sq_flags [ROOT_BITS+1];
  logic [63:0]               sq_trial [ROOT_BITS];
  logic [ROOT_BITS-1:0]      sq_bit   [ROOT_BITS];
  logic [ROOT_BITS-1:0]      sq_fit;

  logic [2:0][NUM_BITS-1:0]  dv_rem   [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0]  dv_q     [QUO_BITS+1];
  logic [DEN_BITS-1:0]       dv_den   [QUO_BITS+1];
  flags_t                    dv_flags [QUO_BITS+1];
  logic [NUM_BITS-1:0]       dv_trial [QUO_BITS];
  logic [2:0]                dv_fit   [QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vchain <= '0;
    end else begin
      vchain <= {vchain[DEPTH-2:0], norm_valid};
    end
  end

  assign res_valid = vchain[DEPTH-1];

  // one root bit per stage
  always_comb begin
    for (int i = 0; i < ROOT_BITS; i++) begin
      sq_bit[i]   = ROOT_BITS'(1) << (ROOT_BITS - 1 - i);
      sq_trial[i] = (64'(sq_root[i]) << (ROOT_BITS - i)) + (64'(1) << (2 * (ROOT_BITS - 1 - i)));
      sq_fit[i]   = 64'(sq_rem[i]) >= sq_trial[i];
    end
  end

  // one quotient bit per stage, three lanes
  always_comb begin
    for (int j = 0; j < QUO_BITS; j++) begin
      dv_trial[j] = NUM_BITS'(dv_den[j]) << (QUO_BITS - 1 - j);
      for (int k = 0; k < 3; k++) begin
        dv_fit[j][k] = dv_rem[j][k] >= dv_trial[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_rem[0]   <= norm.sum;
    sq_root[0]  <= '0;
    sq_mag[0]   <= norm.mag;
    sq_flags[0] <= norm.flags;
    for (int i = 0; i < ROOT_BITS; i++) begin
      sq_rem[i+1]   <= sq_fit[i] ? SUM_BITS'(64'(sq_rem[i]) - sq_trial[i]) : sq_rem[i];
      sq_root[i+1]  <= sq_fit[i] ? (sq_root[i] | sq_bit[i]) : sq_root[i];
      sq_mag[i+1]   <= sq_mag[i];
      sq_flags[i+1] <= sq_flags[i];
    end

    // numerator mag * 2^15 + len over 2 * len rounds half away from zero
    dv_den[0]   <= {sq_root[ROOT_BITS], 1'b0};
    dv_flags[0] <= sq_flags[ROOT_BITS];
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] <= NUM_BITS'({sq_mag[ROOT_BITS][k], QUO_BITS'(0)})
                    + NUM_BITS'(sq_root[ROOT_BITS]);
      dv_q[0][k]   <= '0;
    end
    for (int j = 0; j < QUO_BITS; j++) begin
      dv_den[j+1]   <= dv_den[j];
      dv_flags[j+1] <= dv_flags[j];
      for (int k = 0; k < 3; k++) begin
        dv_rem[j+1][k] <= dv_fit[j][k] ? dv_rem[j][k] - dv_trial[j] : dv_rem[j][k];
        dv_q[j+1][k]   <= dv_fit[j][k] ? (dv_q[j][k] | (QUO_BITS'(1) << (QUO_BITS - 1 - j)))
                                       : dv_q[j][k];
      end
    end

    if (dv_flags[QUO_BITS].degen) begin
      res.normal_x   <= '0;
      res.normal_y   <= '0;
      res.normal_z   <= '0;
      res.degenerate <= 1'b1;
    end else begin
      res.normal_x   <= apply_sign(dv_q[QUO_BITS][0], dv_flags[QUO_BITS].neg[0]);
      res.normal_y   <= apply_sign(dv_q[QUO_BITS][1], dv_flags[QUO_BITS].neg[1]);
      res.normal_z   <= apply_sign(dv_q[QUO_BITS][2], dv_flags[QUO_BITS].neg[2]);
      res.degenerate <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/triangle_unit_normal.sv =====
// Triangle unit normal. A write word stores one vertex position in the vertex memory
// and is taken every cycle while the memory port is free. A query word reads its three
// vertices one after another through the single memory port, and no further word is
// taken until the port is free again. Each query gives one result, through a fixed
// pipeline of edge and cross product stages, a root stage per bit of the length and a
// division stage per bit of the quotient. Up to 32 results wait in an output queue, and
// queries are held off while 32 are in flight.
// The vertex memory needs no clearing pass: a vertex must be written before it is read.
// depends on tun_pkg, tun_fetch, tun_cross and tun_scale
`timescale 1ns / 1ps

module triangle_unit_normal #(
  parameter int VERTEX_COUNT = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tun_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tun_pkg::result_t result
);

  import tun_pkg::*;

  logic                            take, pop, port_free, vtx_valid, norm_valid, res_valid;
  logic [2:0][2:0][COORD_BITS-1:0] vtx;
  norm_t                           norm;
  result_t                         res;
  result_t                         fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]              wr_ptr, rd_ptr;
  logic [FIFO_AW:0]                fill, credits;

  assign item_stall = !port_free
                    || (item.mode == MODE_QUERY && credits == (FIFO_AW+1)'(FIFO_DEPTH));
  assign take       = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;

  tun_fetch #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .COORD_BITS   (COORD_BITS)
  ) u_fetch (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .port_free (port_free),
    .vtx_valid (vtx_valid),
    .vtx       (vtx)
  );

  tun_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk        (clk),
    .rst        (rst),
    .vtx_valid  (vtx_valid),
    .vtx        (vtx),
    .norm_valid (norm_valid),
    .norm       (norm)
  );

  tun_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .norm_valid (norm_valid),
    .norm       (norm),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill    <= fill + (FIFO_AW+1)'(res_valid) - (FIFO_AW+1)'(pop);
      credits <= credits + (FIFO_AW+1)'(take && item.mode == MODE_QUERY) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  assign result_valid = fill != '0;
  assign result       = fifo[rd_ptr];

endmodule

// ===== rtl/core/tun_check.sv =====
// port checker for the triangle unit normal block, bound to the top level
// depends on tun_pkg and triangle_unit_normal_defines.svh
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"

module tun_check (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input tun_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input tun_pkg::result_t result
);

  import tun_pkg::*;

  `TUN_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")
  `TUN_ASSERT(a_degen_zero, result_valid && result.degenerate |-> result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0, "degenerate result with non-zero normal")
  `TUN_ASSERT(a_unit_range, result_valid |-> result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 && result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 && result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384, "normal component out of range")
  `TUN_ASSERT_NEXT(a_query_port, item_valid && !item_stall && item.mode == MODE_QUERY, item_stall, "word taken while vertex reads pending")

endmodule

bind triangle_unit_normal tun_check u_check (.*);
